FILE: design/atsmp_pkg.sv
// atsmp_pkg: shared types and constants for the alias table sampler
// no dependencies; imported by atsmp_mul and alias_table_sampler

package atsmp_pkg;

    localparam int MAX_OUTCOMES = 1024;
    localparam int SLOTS        = MAX_OUTCOMES + 2;
    localparam int SLOT_W       = $clog2(SLOTS);
    localparam int N_W          = 11;
    localparam int FRAC_W       = 32;
    localparam int TH_W         = FRAC_W + 12;
    localparam int PROB_W       = 33;
    localparam int RAND_W       = 32;
    localparam int PROD_W       = PROB_W + N_W;

    localparam logic [TH_W-1:0] TH_ONE = TH_W'(1) << FRAC_W;
    localparam logic [TH_W-1:0] TH_TWO = TH_W'(2) << FRAC_W;
    localparam logic [TH_W-1:0] TH_MAX = (TH_W'(1) << (TH_W - 1)) - TH_W'(1);

    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_BUILD  = 2'd1,
        ACT_SAMPLE = 2'd2,
        ACT_NONE   = 2'd3
    } act_t;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_BUILT = 2'd1;
    localparam logic [1:0] ST_BAD_INDEX = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LD,
        S_SM_MUL,
        S_SM_RD,
        S_SM_OUT,
        S_INIT,
        S_I_CHK,
        S_I_WO,
        S_I_TH,
        S_J_CHK,
        S_J_WO,
        S_J_TH,
        S_P1_END,
        S_SWAP2,
        S_Q_TOP,
        S_Q_JCHK,
        S_Q_JWO,
        S_Q_JTH,
        S_Q_IWO,
        S_Q_ITH,
        S_Q_UPD,
        S_Q_SW2
    } state_t;

endpackage

FILE: design/atsmp_ram.sv
// atsmp_ram: simple dual-port ram, one write and one registered read port
// generic storage; no package dependencies

module atsmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/atsmp_mul.sv
// atsmp_mul: shared multiplier scaling a q1.32 operand by the outcome count
// depends on atsmp_pkg

module atsmp_mul
    import atsmp_pkg::*;
(
    input  logic [PROB_W-1:0] a,
    input  logic [N_W-1:0]    n,
    output logic [PROD_W-1:0] p
);

    assign p = PROD_W'(a) * PROD_W'(n);

endmodule

FILE: design/alias_table_sampler.sv
// alias_table_sampler: walker alias-method sampler, sequencer and datapath
// a load steps through S_LD, a sample through S_SM_MUL, S_SM_RD and S_SM_OUT;
// a build's length is set by the single-port walks over the order, threshold and alias rams
// one result beat per item, shown on done for one cycle; receiver cannot stall
// busy is high from accept until the result beat; async active-low reset
// clears the sequencer and ready flag and sets n_outcomes to 1024

module alias_table_sampler
    import atsmp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         action,
    input  logic [N_W-1:0]     entry_index,
    input  logic [PROB_W-1:0]  probability,
    input  logic [RAND_W-1:0]  rand_pick,
    input  logic [RAND_W-1:0]  rand_draw,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [N_W-1:0]     cfg_data,
    output logic               done,
    output logic [N_W-1:0]     outcome,
    output logic               table_ready,
    output logic [1:0]         status
);

    state_t state_reg, state_next;
    logic [N_W-1:0]    n_reg;
    logic              ready_reg, ready_next;
    logic [SLOT_W-1:0] i_reg, i_next, j_reg, j_next;
    logic [SLOT_W-1:0] a_reg, a_next, b_reg, b_next;
    logic [TH_W-1:0]   thj_reg, thj_next;
    logic [PROB_W-1:0] prob_reg, prob_next;
    logic [RAND_W-1:0] pick_reg, pick_next, draw_reg, draw_next;
    logic              done_reg, done_next;
    logic [N_W-1:0]    outcome_reg, outcome_next;
    logic [1:0]        status_reg, status_next;

    logic [N_W-1:0]    n_eff;
    logic [SLOT_W-1:0] n_slot, n_top;
    logic [PROB_W-1:0] mul_a;
    logic [PROD_W-1:0] mul_p;
    logic [TH_W-1:0]   th_new;

    logic              th_we, al_we, wo_we;
    logic [SLOT_W-1:0] th_waddr, th_raddr, al_waddr, al_raddr, wo_waddr, wo_raddr;
    logic [TH_W-1:0]   th_wdata, th_rdata;
    logic [SLOT_W-1:0] al_wdata, al_rdata, wo_wdata, wo_rdata;

    atsmp_ram #(.WIDTH(TH_W), .DEPTH(SLOTS)) u_th (
        .clk(clk), .we(th_we), .waddr(th_waddr), .wdata(th_wdata),
        .raddr(th_raddr), .rdata(th_rdata)
    );

    atsmp_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_alias (
        .clk(clk), .we(al_we), .waddr(al_waddr), .wdata(al_wdata),
        .raddr(al_raddr), .rdata(al_rdata)
    );

    atsmp_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_order (
        .clk(clk), .we(wo_we), .waddr(wo_waddr), .wdata(wo_wdata),
        .raddr(wo_raddr), .rdata(wo_rdata)
    );

    atsmp_mul u_mul (
        .a(mul_a), .n(n_eff), .p(mul_p)
    );

    always_comb
    begin
        if (n_reg == '0)
        begin
            n_eff = N_W'(1);
        end
        else if (n_reg > N_W'(MAX_OUTCOMES))
        begin
            n_eff = N_W'(MAX_OUTCOMES);
        end
        else
        begin
            n_eff = n_reg;
        end
    end

    assign n_slot = SLOT_W'(n_eff);
    assign n_top  = n_slot + SLOT_W'(1);
    assign mul_a  = (state_reg == S_LD) ? prob_reg : PROB_W'(pick_reg);
    assign th_new = thj_reg - TH_ONE + th_rdata;

    assign busy        = (state_reg != S_IDLE);
    assign cfg_ready   = (state_reg == S_IDLE);
    assign done        = done_reg;
    assign outcome     = outcome_reg;
    assign status      = status_reg;
    assign table_ready = ready_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            n_reg     <= N_W'(MAX_OUTCOMES);
            ready_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                n_reg     <= cfg_data;
                ready_reg <= 1'b0;
            end
            else
            begin
                ready_reg <= ready_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg       <= i_next;
        j_reg       <= j_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        thj_reg     <= thj_next;
        prob_reg    <= prob_next;
        pick_reg    <= pick_next;
        draw_reg    <= draw_next;
        outcome_reg <= outcome_next;
        status_reg  <= status_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        ready_next   = ready_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        thj_next     = thj_reg;
        prob_next    = prob_reg;
        pick_next    = pick_reg;
        draw_next    = draw_reg;
        done_next    = 1'b0;
        outcome_next = outcome_reg;
        status_next  = status_reg;
        th_we        = 1'b0;
        th_waddr     = i_reg;
        th_wdata     = '0;
        th_raddr     = wo_rdata;
        al_we        = 1'b0;
        al_waddr     = i_reg;
        al_wdata     = i_reg;
        al_raddr     = i_reg;
        wo_we        = 1'b0;
        wo_waddr     = i_reg;
        wo_wdata     = i_reg;
        wo_raddr     = i_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    prob_next    = probability;
                    pick_next    = rand_pick;
                    draw_next    = rand_draw;
                    i_next       = SLOT_W'(entry_index);
                    outcome_next = '0;
                    status_next  = ST_OK;
                    case (act_t'(action))
                        ACT_LOAD:
                        begin
                            if (entry_index == '0 || entry_index > n_eff)
                            begin
                                status_next = ST_BAD_INDEX;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                state_next = S_LD;
                            end
                        end
                        ACT_BUILD:
                        begin
                            i_next     = '0;
                            state_next = S_INIT;
                        end
                        ACT_SAMPLE:
                        begin
                            if (!ready_reg)
                            begin
                                status_next = ST_NOT_BUILT;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                state_next = S_SM_MUL;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_LD:
            begin
                th_we      = 1'b1;
                th_waddr   = i_reg;
                th_wdata   = mul_p[PROD_W-1] ? TH_MAX : TH_W'(mul_p);
                ready_next = 1'b0;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_SM_MUL:
            begin
                i_next     = SLOT_W'(1) + SLOT_W'(mul_p[FRAC_W +: N_W]);
                state_next = S_SM_RD;
            end
            S_SM_RD:
            begin
                th_raddr   = i_reg;
                al_raddr   = i_reg;
                state_next = S_SM_OUT;
            end
            S_SM_OUT:
            begin
                if ($signed(th_rdata) < $signed(TH_W'(draw_reg)))
                begin
                    outcome_next = N_W'(al_rdata);
                end
                else
                begin
                    outcome_next = N_W'(i_reg);
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            // slot k aliases and orders to itself; sentinels at both ends
            S_INIT:
            begin
                al_we    = 1'b1;
                wo_we    = 1'b1;
                th_waddr = i_reg;
                if (i_reg == '0)
                begin
                    th_we    = 1'b1;
                    th_wdata = '0;
                end
                if (i_reg == n_top)
                begin
                    th_we      = 1'b1;
                    th_wdata   = TH_TWO;
                    i_next     = SLOT_W'(1);
                    j_next     = n_top;
                    state_next = S_I_CHK;
                end
                else
                begin
                    i_next = i_reg + SLOT_W'(1);
                end
            end
            // partition: small entries left, large right
            S_I_CHK:
            begin
                if (i_reg > n_slot)
                begin
                    j_next     = j_reg - SLOT_W'(1);
                    state_next = S_J_CHK;
                end
                else
                begin
                    wo_raddr   = i_reg;
                    state_next = S_I_WO;
                end
            end
            S_I_WO:
            begin
                a_next     = wo_rdata;
                state_next = S_I_TH;
            end
            S_I_TH:
            begin
                if ($signed(th_rdata) < $signed(TH_ONE))
                begin
                    i_next     = i_reg + SLOT_W'(1);
                    state_next = S_I_CHK;
                end
                else
                begin
                    j_next     = j_reg - SLOT_W'(1);
                    state_next = S_J_CHK;
                end
            end
            S_J_CHK:
            begin
                if (j_reg == '0)
                begin
                    state_next = S_P1_END;
                end
                else
                begin
                    wo_raddr   = j_reg;
                    state_next = S_J_WO;
                end
            end
            S_J_WO:
            begin
                b_next     = wo_rdata;
                state_next = S_J_TH;
            end
            S_J_TH:
            begin
                if ($signed(th_rdata) >= $signed(TH_ONE))
                begin
                    j_next     = j_reg - SLOT_W'(1);
                    state_next = S_J_CHK;
                end
                else
                begin
                    state_next = S_P1_END;
                end
            end
            S_P1_END:
            begin
                if (j_reg <= i_reg)
                begin
                    i_next     = j_reg;
                    j_next     = j_reg + SLOT_W'(1);
                    state_next = S_Q_TOP;
                end
                else
                begin
                    wo_we      = 1'b1;
                    wo_waddr   = i_reg;
                    wo_wdata   = b_reg;
                    state_next = S_SWAP2;
                end
            end
            S_SWAP2:
            begin
                wo_we      = 1'b1;
                wo_waddr   = j_reg;
                wo_wdata   = a_reg;
                i_next     = i_reg + SLOT_W'(1);
                state_next = S_I_CHK;
            end
            // donation: small entries take their remainder from large ones
            S_Q_TOP:
            begin
                if (i_reg == '0)
                begin
                    ready_next = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_Q_JCHK;
                end
            end
            S_Q_JCHK:
            begin
                if (j_reg > n_slot)
                begin
                    ready_next = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    wo_raddr   = j_reg;
                    state_next = S_Q_JWO;
                end
            end
            S_Q_JWO:
            begin
                b_next     = wo_rdata;
                state_next = S_Q_JTH;
            end
            S_Q_JTH:
            begin
                thj_next = th_rdata;
                if ($signed(th_rdata) <= $signed(TH_ONE))
                begin
                    j_next     = j_reg + SLOT_W'(1);
                    state_next = S_Q_JCHK;
                end
                else
                begin
                    wo_raddr   = i_reg;
                    state_next = S_Q_IWO;
                end
            end
            S_Q_IWO:
            begin
                a_next     = wo_rdata;
                state_next = S_Q_ITH;
            end
            S_Q_ITH:
            begin
                th_we      = 1'b1;
                th_waddr   = b_reg;
                th_wdata   = th_new;
                thj_next   = th_new;
                al_we      = 1'b1;
                al_waddr   = a_reg;
                al_wdata   = b_reg;
                state_next = S_Q_UPD;
            end
            S_Q_UPD:
            begin
                if ($signed(thj_reg) < $signed(TH_ONE))
                begin
                    wo_we      = 1'b1;
                    wo_waddr   = i_reg;
                    wo_wdata   = b_reg;
                    state_next = S_Q_SW2;
                end
                else
                begin
                    i_next     = i_reg - SLOT_W'(1);
                    state_next = S_Q_TOP;
                end
            end
            S_Q_SW2:
            begin
                wo_we      = 1'b1;
                wo_waddr   = j_reg;
                wo_wdata   = a_reg;
                j_next     = j_reg + SLOT_W'(1);
                state_next = S_Q_TOP;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while sequencer still busy");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> outcome == '0)
        else $error("error beat carries an outcome");

    a_hit_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (done && outcome != '0) |-> (table_ready && status == ST_OK))
        else $error("outcome without a built table");

    a_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> outcome <= n_eff)
        else $error("outcome beyond outcome count");

endmodule
